/* rtl/rphr_pkg.sv */
// rphr_pkg: shared constants and the word carried along the divider chain
// of ranged_position_hash_random. no dependencies.
`default_nettype none

package rphr_pkg;

  localparam int unsigned Width    = 32;
  localparam int unsigned NumCells = Width;

  // hash constants
  localparam logic [Width-1:0] KeyMul1  = 32'd1913;
  localparam logic [Width-1:0] KeyMul2  = 32'd757;
  localparam logic [Width-1:0] MixMul   = 32'd73;
  localparam logic [Width-1:0] MixXor   = 32'd326881591;
  localparam logic [Width-1:0] Mod7213  = 32'd7213;
  localparam int unsigned      MixShift = 16;

  // reciprocal of 7213, floor(2^44 / 7213), fits in 32 bits
  localparam int unsigned      RecipShift = 44;
  localparam longint unsigned  RecipWide  = (64'd1 << RecipShift) / 64'd7213;
  localparam logic [Width-1:0] Recip7213  = RecipWide[Width-1:0];

  localparam logic [Width-1:0] MinS32 = 32'h8000_0000;
  localparam logic [Width-1:0] MaxS32 = 32'h7FFF_FFFF;

  // word handed from cell to cell in the remainder chain
  typedef struct packed {
    logic [Width-1:0] lo;    // lower bound after swap
    logic             full;  // full signed range, return raw hash
    logic [Width-1:0] hash;  // raw hash
    logic             neg;   // hash is negative
    logic [Width-1:0] num;   // remaining dividend bits, msb first
    logic [Width-1:0] rem;   // partial remainder
    logic [Width-1:0] den;   // magnitude of the span
  } div_t;

endpackage

`default_nettype wire

/* rtl/ranged_position_hash_random.sv */
// ranged_position_hash_random: top level, hash front end, remainder chain
// of rphr_div_cell and output register. depends on rphr_pkg, rphr_hash,
// rphr_div_cell.
//
//   channel  handshake               payload
//   in       in_valid_i / in_stall_o  bounds, keys, time, seed and override
//   out      out_valid_o / out_stall_i random_value_o
//
// one word per cycle sustained while out_stall_i is low. from acceptance
// to out_valid_o: six hash stages, 32 remainder cells, one output register
// the 32-cell restoring remainder chain sets the latency
// reset clears only the valid bits, payload registers keep no reset
// every stage moves when it is empty or the next one moves, so bubbles
// collapse and input is taken while a result waits on a stalled output
`default_nettype none

module ranged_position_hash_random (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [rphr_pkg::Width-1:0] low_bound_i,
  input  logic [rphr_pkg::Width-1:0] high_bound_i,
  input  logic [rphr_pkg::Width-1:0] first_key_i,
  input  logic [rphr_pkg::Width-1:0] second_key_i,
  input  logic [rphr_pkg::Width-1:0] elapsed_time_i,
  input  logic                       has_user_seed_i,
  input  logic [rphr_pkg::Width-1:0] user_seed_i,
  input  logic                       has_time_override_i,
  input  logic [rphr_pkg::Width-1:0] time_override_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [rphr_pkg::Width-1:0] random_value_o
);

  localparam int unsigned W = rphr_pkg::Width;
  localparam int unsigned N = rphr_pkg::NumCells;

  // chain links: index 0 is the hash output, index N the last cell
  logic           link_valid [N+1];
  logic           link_ready [N+1];
  rphr_pkg::div_t link_data  [N+1];

  logic           hash_ready;
  logic           out_valid_q;
  logic [W-1:0]   out_value_q;
  logic           out_ready;
  logic [W-1:0]   rem_signed;

  // front end: swap, seed, mixing hash, span magnitude
  rphr_hash u_hash (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .valid_i             (in_valid_i),
    .ready_o             (hash_ready),
    .low_bound_i         (low_bound_i),
    .high_bound_i        (high_bound_i),
    .first_key_i         (first_key_i),
    .second_key_i        (second_key_i),
    .elapsed_time_i      (elapsed_time_i),
    .has_user_seed_i     (has_user_seed_i),
    .user_seed_i         (user_seed_i),
    .has_time_override_i (has_time_override_i),
    .time_override_i     (time_override_i),
    .valid_o             (link_valid[0]),
    .ready_i             (link_ready[0]),
    .data_o              (link_data[0])
  );

  assign in_stall_o = !hash_ready;

  // remainder chain, one dividend bit per cell, msb first
  for (genvar i = 0; i < N; i++) begin : g_cell
    rphr_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (link_valid[i]),
      .ready_o (link_ready[i]),
      .data_i  (link_data[i]),
      .valid_o (link_valid[i+1]),
      .ready_i (link_ready[i+1]),
      .data_o  (link_data[i+1])
    );
  end

  // output register, takes the last cell's word when free or being drained
  assign out_ready     = !out_valid_q || !out_stall_i;
  assign link_ready[N] = out_ready;

  // remainder takes the sign of the hash (truncating remainder)
  assign rem_signed = link_data[N].neg ? (W'(0) - link_data[N].rem) : link_data[N].rem;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= link_valid[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready) begin
      // full signed range returns the raw hash
      out_value_q <= link_data[N].full ? link_data[N].hash : (link_data[N].lo + rem_signed);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign random_value_o = out_value_q;

  // input is only held off when the whole pipe is full and the output stalls
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && link_valid[N] && link_valid[0]))
    else $error("input stalled with room in the pipe");

  // finished remainder is below the span magnitude
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (link_valid[N] && !link_data[N].full) |-> (link_data[N].rem < link_data[N].den))
    else $error("remainder not below span");

  // a word blocked at the end of the chain is held
  a_chain_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (link_valid[N] && !out_ready) |=> (link_valid[N] && $stable(link_data[N])))
    else $error("chain word lost under stall");

endmodule

`default_nettype wire

/* rtl/rphr_hash.sv */
// rphr_hash: six-stage front end, bound swap, seed and mixing hash,
// emits the first word of the remainder chain. depends on rphr_pkg.
`default_nettype none

module rphr_hash (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic [rphr_pkg::Width-1:0]   low_bound_i,
  input  logic [rphr_pkg::Width-1:0]   high_bound_i,
  input  logic [rphr_pkg::Width-1:0]   first_key_i,
  input  logic [rphr_pkg::Width-1:0]   second_key_i,
  input  logic [rphr_pkg::Width-1:0]   elapsed_time_i,
  input  logic                         has_user_seed_i,
  input  logic [rphr_pkg::Width-1:0]   user_seed_i,
  input  logic                         has_time_override_i,
  input  logic [rphr_pkg::Width-1:0]   time_override_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output rphr_pkg::div_t               data_o
);

  localparam int unsigned W = rphr_pkg::Width;
  localparam int unsigned QBits = 2 * W - rphr_pkg::RecipShift;

  logic [6:1] v_q;
  logic [6:1] rdy;

  // stage registers
  logic [W-1:0] s1_lo_q, s1_hi_q, s1_keys_q, s1_useed_q, s1_t_q;
  logic         s1_seed_q;
  logic [W-1:0] s2_a_q, s2_lo_q, s2_span_q;
  logic         s2_full_q;
  logic [W-1:0] s3_x_q, s3_a_q, s3_abs_q, s3_lo_q, s3_den_q;
  logic [2*W-1:0] s3_prod_q;
  logic         s3_neg_q, s3_full_q;
  logic [W-1:0] s4_r_q, s4_x_q, s4_a_q, s4_lo_q, s4_den_q;
  logic         s4_neg_q, s4_full_q;
  logic [W-1:0] s5_b_q, s5_lo_q, s5_den_q;
  logic         s5_full_q;
  rphr_pkg::div_t s6_q;

  assign rdy[6] = !v_q[6] || ready_i;
  assign rdy[5] = !v_q[5] || rdy[6];
  assign rdy[4] = !v_q[4] || rdy[5];
  assign rdy[3] = !v_q[3] || rdy[4];
  assign rdy[2] = !v_q[2] || rdy[3];
  assign rdy[1] = !v_q[1] || rdy[2];
  assign ready_o = rdy[1];
  assign valid_o = v_q[6];
  assign data_o  = s6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[1]) v_q[1] <= valid_i;
      if (rdy[2]) v_q[2] <= v_q[1];
      if (rdy[3]) v_q[3] <= v_q[2];
      if (rdy[4]) v_q[4] <= v_q[3];
      if (rdy[5]) v_q[5] <= v_q[4];
      if (rdy[6]) v_q[6] <= v_q[5];
    end
  end

  // stage 1: swap, key products, time select
  logic swap;
  assign swap = $signed(low_bound_i) > $signed(high_bound_i);

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      s1_lo_q    <= swap ? high_bound_i : low_bound_i;
      s1_hi_q    <= swap ? low_bound_i : high_bound_i;
      s1_keys_q  <= W'(first_key_i * rphr_pkg::KeyMul1)
                  ^ W'(second_key_i * rphr_pkg::KeyMul2);
      s1_seed_q  <= has_user_seed_i;
      s1_useed_q <= user_seed_i;
      s1_t_q     <= (has_user_seed_i && has_time_override_i) ? time_override_i
                                                             : elapsed_time_i;
    end
  end

  // stage 2: seed, first mix, span and full-range flag
  logic [W-1:0] seed, tmix;
  always_comb begin
    seed = s1_keys_q;
    if (s1_seed_q) begin
      seed = s1_useed_q[W-1] ? (W'(0) - s1_useed_q) : (s1_keys_q + s1_useed_q);
    end
    tmix = (s1_t_q << 7) ^ {{2{s1_t_q[W-1]}}, s1_t_q[W-1:2]} ^ s1_t_q;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      s2_a_q    <= seed + tmix;
      s2_lo_q   <= s1_lo_q;
      s2_span_q <= s1_hi_q - s1_lo_q + W'(1);
      s2_full_q <= (s1_lo_q == rphr_pkg::MinS32) && (s1_hi_q == rphr_pkg::MaxS32);
    end
  end

  // stage 3: constant multiply and reciprocal product for the mod 7213
  logic [W-1:0] a_abs;
  assign a_abs = s2_a_q[W-1] ? (W'(0) - s2_a_q) : s2_a_q;

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      s3_x_q    <= W'(s2_a_q * rphr_pkg::MixMul) ^ rphr_pkg::MixXor;
      s3_a_q    <= s2_a_q;
      s3_abs_q  <= a_abs;
      s3_neg_q  <= s2_a_q[W-1];
      s3_prod_q <= {{W{1'b0}}, a_abs} * {{W{1'b0}}, rphr_pkg::Recip7213};
      s3_lo_q   <= s2_lo_q;
      s3_full_q <= s2_full_q;
      s3_den_q  <= s2_span_q[W-1] ? (W'(0) - s2_span_q) : s2_span_q;
    end
  end

  // stage 4: residue from the quotient estimate, below twice 7213
  logic [QBits-1:0] quot;
  assign quot = s3_prod_q[2*W-1:rphr_pkg::RecipShift];

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      s4_r_q    <= s3_abs_q - W'({{(W-QBits){1'b0}}, quot} * rphr_pkg::Mod7213);
      s4_x_q    <= s3_x_q;
      s4_a_q    <= s3_a_q;
      s4_neg_q  <= s3_neg_q;
      s4_lo_q   <= s3_lo_q;
      s4_full_q <= s3_full_q;
      s4_den_q  <= s3_den_q;
    end
  end

  // stage 5: correction, sign, second mix sum
  logic [W-1:0] r_fix, r_sgn;
  always_comb begin
    r_fix = (s4_r_q >= rphr_pkg::Mod7213) ? (s4_r_q - rphr_pkg::Mod7213) : s4_r_q;
    r_sgn = s4_neg_q ? (W'(0) - r_fix) : r_fix;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      s5_b_q    <= s4_x_q + r_sgn + s4_a_q;
      s5_lo_q   <= s4_lo_q;
      s5_full_q <= s4_full_q;
      s5_den_q  <= s4_den_q;
    end
  end

  // stage 6: final mix, start word for the chain
  logic [W-1:0] c_mix, d_mix;
  always_comb begin
    c_mix = s5_b_q ^ (s5_b_q << 7) ^ {{2{s5_b_q[W-1]}}, s5_b_q[W-1:2]};
    d_mix = {{rphr_pkg::MixShift{c_mix[W-1]}}, c_mix[W-1:rphr_pkg::MixShift]} ^ c_mix;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[6]) begin
      s6_q.lo   <= s5_lo_q;
      s6_q.full <= s5_full_q;
      s6_q.hash <= d_mix;
      s6_q.neg  <= d_mix[W-1];
      s6_q.num  <= d_mix[W-1] ? (W'(0) - d_mix) : d_mix;
      s6_q.rem  <= '0;
      s6_q.den  <= s5_den_q;
    end
  end

endmodule

`default_nettype wire

/* rtl/rphr_div_cell.sv */
// rphr_div_cell: one restoring remainder step, holds one word and hands it
// to the next cell. depends on rphr_pkg.
`default_nettype none

module rphr_div_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  rphr_pkg::div_t data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output rphr_pkg::div_t data_o
);

  localparam int unsigned W = rphr_pkg::Width;

  logic           valid_q;
  rphr_pkg::div_t data_q, data_d;
  logic [W:0]     trial;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    data_d     = data_i;
    trial      = {data_i.rem, data_i.num[W-1]};
    data_d.num = data_i.num << 1;
    if (trial >= {1'b0, data_i.den}) begin
      data_d.rem = W'(trial - {1'b0, data_i.den});
    end else begin
      data_d.rem = trial[W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

`default_nettype wire
